[rtl/lli_pkg.sv]
package lli_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;

	// field widths
	localparam int STEP_W  = 16;
	localparam int START_W = 30;
	localparam int COUNT_W = 11;
	localparam int VALUE_W = 32;
	localparam int INDEX_W = 10;
	localparam int DATA_W  = 16;
	localparam int LOG_W   = 16;

	// configuration port
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 30;

	localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_STEP = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_START_VALUE = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_ENTRY_COUNT = 2'd2;

	localparam logic [STEP_W-1:0]  STEP_RST  = 16'd1;
	localparam logic [START_W-1:0] START_RST = 30'd4096;
	localparam logic [COUNT_W-1:0] COUNT_RST = 11'd1;

	// index divider: positive offset (31 bits, zero extended) by the step
	localparam int DIV1_DVD_W  = 32;
	localparam int DIV1_QUOT_W = 31;
	// interpolation divider: quotient stays below the sample difference
	localparam int DIV2_DVD_W  = 32;
	localparam int DIV2_QUOT_W = 16;

	typedef struct packed {
		logic               eval;
		logic               dpos;
		logic [INDEX_W-1:0] index;
		logic [DATA_W-1:0]  data;
	} lkup_tag_t;

	typedef struct packed {
		logic [DATA_W-1:0] t0;
		logic              neg;
	} interp_tag_t;

endpackage

[rtl/lli_if.sv]
interface lli_req_if;
	logic                                valid;
	logic                                ready;
	logic                                cmd;
	logic signed [lli_pkg::VALUE_W-1:0]  value_in;
	logic        [lli_pkg::INDEX_W-1:0]  entry_index;
	logic signed [lli_pkg::DATA_W-1:0]   entry_data;

	modport source (output valid, cmd, value_in, entry_index, entry_data, input ready);
	modport sink (input valid, cmd, value_in, entry_index, entry_data, output ready);
endinterface

interface lli_rsp_if;
	logic                              valid;
	logic                              ready;
	logic signed [lli_pkg::LOG_W-1:0]  log_out;

	modport source (output valid, log_out, input ready);
	modport sink (input valid, log_out, output ready);
endinterface

interface lli_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [lli_pkg::CFG_ADDR_W-1:0]     index;
	logic [lli_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/lli_ram.sv]
module lli_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

[rtl/lli_div.sv]
module lli_div #(
	parameter int DIVIDEND_W = 32,
	parameter int QUOT_W     = 31,
	parameter int DIVISOR_W  = 16,
	parameter int TAG_W      = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	input  logic [TAG_W-1:0]      tag_in,
	output logic                  out_valid,
	output logic [QUOT_W-1:0]     quotient,
	output logic [DIVISOR_W-1:0]  remainder,
	output logic [TAG_W-1:0]      tag_out
);

	// one quotient bit per stage; the bits above QUOT_W must already be below the divisor
	logic                 vld_s [QUOT_W];
	logic [DIVISOR_W-1:0] rem_s [QUOT_W];
	logic [QUOT_W-1:0]    wrk_s [QUOT_W];
	logic [TAG_W-1:0]     tag_s [QUOT_W];

	for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
		logic                 cur_vld;
		logic [DIVISOR_W-1:0] cur_rem;
		logic [QUOT_W-1:0]    cur_wrk;
		logic [TAG_W-1:0]     cur_tag;
		logic [DIVISOR_W:0]   trial;
		logic                 fit;

		if (k == 0) begin : g_first
			assign cur_vld = in_valid;
			assign cur_rem = DIVISOR_W'(dividend[DIVIDEND_W-1:QUOT_W]);
			assign cur_wrk = dividend[QUOT_W-1:0];
			assign cur_tag = tag_in;
		end else begin : g_next
			assign cur_vld = vld_s[k-1];
			assign cur_rem = rem_s[k-1];
			assign cur_wrk = wrk_s[k-1];
			assign cur_tag = tag_s[k-1];
		end

		assign trial = {cur_rem, cur_wrk[QUOT_W-1]};
		assign fit   = trial >= {1'b0, divisor};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= fit ? DIVISOR_W'(trial - {1'b0, divisor}) : trial[DIVISOR_W-1:0];
				wrk_s[k] <= {cur_wrk[QUOT_W-2:0], fit};
				tag_s[k] <= cur_tag;
			end
		end
	end

	assign out_valid = vld_s[QUOT_W-1];
	assign quotient  = wrk_s[QUOT_W-1];
	assign remainder = rem_s[QUOT_W-1];
	assign tag_out   = tag_s[QUOT_W-1];

endmodule

[rtl/fixed_point_log_interp_lookup.sv]
// channel  direction  payload
// req      in         cmd, value_in, entry_index, entry_data
// rsp      out        log_out (one per evaluation, none per table write)
// cfg      in         index, data (sample_step, start_value, entry_count)
//
// one transaction per cycle on req while req.ready is high; an evaluation passes the
// stages below and waits in the output buffer until its result is taken on rsp.
// pipeline: offset stage, 31-stage index divider, table read, two arithmetic stages,
// 16-stage interpolation divider, output register.
// table writes travel the same pipeline and land at the read stage, so order is kept.
// the sample table has no reset; configuration registers reset to their defaults.
// req stalls only while two results wait on rsp and a third reaches the end.
module fixed_point_log_interp_lookup #(
	parameter int TABLE_DEPTH = lli_pkg::TABLE_DEPTH_DEF
) (
	input logic         clk,
	input logic         arst_n,
	lli_req_if.sink     req,
	lli_rsp_if.source   rsp,
	lli_cfg_if.sink     cfg
);

	localparam int AW = $clog2(TABLE_DEPTH);

	// configuration
	logic [lli_pkg::STEP_W-1:0]  step_q;
	logic [lli_pkg::START_W-1:0] start_q;
	logic [lli_pkg::COUNT_W-1:0] count_q;
	logic [lli_pkg::STEP_W-1:0]  step_eff;
	logic [AW-1:0]               last_idx;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= lli_pkg::STEP_RST;
			start_q <= lli_pkg::START_RST;
			count_q <= lli_pkg::COUNT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				lli_pkg::REG_SAMPLE_STEP: step_q  <= cfg.data[lli_pkg::STEP_W-1:0];
				lli_pkg::REG_START_VALUE: start_q <= cfg.data[lli_pkg::START_W-1:0];
				lli_pkg::REG_ENTRY_COUNT: count_q <= cfg.data[lli_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign step_eff = (step_q == '0) ? lli_pkg::STEP_W'(1) : step_q;

	always_comb begin
		if (count_q == '0) begin
			last_idx = '0;
		end else if (32'(count_q) > 32'(TABLE_DEPTH)) begin
			last_idx = AW'(TABLE_DEPTH - 1);
		end else begin
			last_idx = AW'(count_q - lli_pkg::COUNT_W'(1));
		end
	end

	// global advance; the end of the pipeline only blocks when the output buffer is full
	logic       adv;
	logic [1:0] cnt_q;
	logic       d2_vld;

	assign adv       = !(d2_vld && cnt_q == 2'd2);
	assign req.ready = adv;

	// stage 1: offset from the first sample
	logic [32:0]               d_full;
	logic                      vld_s1;
	logic [30:0]               dvd_s1;
	lli_pkg::lkup_tag_t        tag_s1;

	assign d_full = {req.value_in[31], req.value_in} - {3'b000, start_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dvd_s1       <= d_full[30:0];
			tag_s1.eval  <= req.cmd;
			tag_s1.dpos  <= !d_full[32] && (d_full != '0);
			tag_s1.index <= req.entry_index;
			tag_s1.data  <= req.entry_data;
		end
	end

	// index divider
	logic                        d1_vld;
	logic [lli_pkg::DIV1_QUOT_W-1:0] d1_q;
	logic [lli_pkg::STEP_W-1:0]  d1_r;
	lli_pkg::lkup_tag_t          d1_tag;

	lli_div #(
		.DIVIDEND_W (lli_pkg::DIV1_DVD_W),
		.QUOT_W     (lli_pkg::DIV1_QUOT_W),
		.DIVISOR_W  (lli_pkg::STEP_W),
		.TAG_W      ($bits(lli_pkg::lkup_tag_t))
	) u_div_idx (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s1),
		.dividend  ({1'b0, dvd_s1}),
		.divisor   (step_eff),
		.tag_in    (tag_s1),
		.out_valid (d1_vld),
		.quotient  (d1_q),
		.remainder (d1_r),
		.tag_out   (d1_tag)
	);

	// table access: writes and reads meet here in arrival order, so no forwarding is needed
	logic                       in_range;
	logic                       interp;
	logic [AW-1:0]              addr_a;
	logic [AW-1:0]              addr_b;
	logic                       ram_we;
	logic                       ram_re;
	logic [lli_pkg::DATA_W-1:0] rd_a;
	logic [lli_pkg::DATA_W-1:0] rd_b;

	assign in_range = d1_q < lli_pkg::DIV1_QUOT_W'(last_idx);
	assign interp   = d1_tag.dpos && in_range && (d1_r != '0);
	assign addr_a   = !d1_tag.dpos ? '0 : (in_range ? d1_q[AW-1:0] : last_idx);
	assign addr_b   = d1_q[AW-1:0] + AW'(1);
	assign ram_we   = adv && d1_vld && !d1_tag.eval && (32'(d1_tag.index) < 32'(TABLE_DEPTH));
	assign ram_re   = adv && d1_vld && d1_tag.eval;

	lli_ram #(
		.WIDTH (lli_pkg::DATA_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (AW'(d1_tag.index)),
		.wdata   (d1_tag.data),
		.re      (ram_re),
		.raddr_a (addr_a),
		.raddr_b (addr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// stage 2: alongside the table read
	logic                       ev_s2;
	logic                       interp_s2;
	logic [lli_pkg::STEP_W-1:0] rem_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_s2 <= 1'b0;
		end else if (adv) begin
			ev_s2 <= d1_vld && d1_tag.eval;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			interp_s2 <= interp;
			rem_s2    <= d1_r;
		end
	end

	// stage 3: sample difference as sign and magnitude
	logic [16:0]                diff;
	logic [16:0]                diff_mag;
	logic                       ev_s3;
	logic [lli_pkg::DATA_W-1:0] t0_s3;
	logic                       neg_s3;
	logic [15:0]                mag_s3;
	logic [lli_pkg::STEP_W-1:0] rem_s3;

	assign diff     = {rd_b[15], rd_b} - {rd_a[15], rd_a};
	assign diff_mag = diff[16] ? 17'(17'd0 - diff) : diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_s3 <= 1'b0;
		end else if (adv) begin
			ev_s3 <= ev_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t0_s3  <= rd_a;
			neg_s3 <= diff[16];
			mag_s3 <= interp_s2 ? diff_mag[15:0] : '0;
			rem_s3 <= rem_s2;
		end
	end

	// stage 4: scale by the fraction numerator
	logic                       ev_s4;
	logic [31:0]                prod_s4;
	lli_pkg::interp_tag_t       itag_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_s4 <= 1'b0;
		end else if (adv) begin
			ev_s4 <= ev_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s4     <= mag_s3 * rem_s3;
			itag_s4.t0  <= t0_s3;
			itag_s4.neg <= neg_s3;
		end
	end

	// interpolation divider, truncates the magnitude toward zero
	logic [lli_pkg::DIV2_QUOT_W-1:0] d2_q;
	lli_pkg::interp_tag_t            d2_tag;
	logic [lli_pkg::LOG_W-1:0]       res;

	lli_div #(
		.DIVIDEND_W (lli_pkg::DIV2_DVD_W),
		.QUOT_W     (lli_pkg::DIV2_QUOT_W),
		.DIVISOR_W  (lli_pkg::STEP_W),
		.TAG_W      ($bits(lli_pkg::interp_tag_t))
	) u_div_frac (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (ev_s4),
		.dividend  (prod_s4),
		.divisor   (step_eff),
		.tag_in    (itag_s4),
		.out_valid (d2_vld),
		.quotient  (d2_q),
		.remainder (),
		.tag_out   (d2_tag)
	);

	assign res = d2_tag.t0 + (d2_tag.neg ? lli_pkg::LOG_W'(16'd0 - d2_q) : d2_q);

	// two-entry output buffer
	logic                      push;
	logic                      pop;
	logic [lli_pkg::LOG_W-1:0] head_q;
	logic [lli_pkg::LOG_W-1:0] skid_q;

	assign push        = adv && d2_vld;
	assign pop         = rsp.valid && rsp.ready;
	assign rsp.valid   = cnt_q != 2'd0;
	assign rsp.log_out = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop && cnt_q == 2'd2) begin
			head_q <= skid_q;
		end else if (push && (cnt_q == 2'd0 || pop)) begin
			head_q <= res;
		end
		if (push && !pop && cnt_q == 2'd1) begin
			skid_q <= res;
		end
	end

endmodule

[rtl/lli_chk.sv]
module lli_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             req_valid,
	input logic                             req_ready,
	input logic                             req_cmd,
	input logic                             rsp_valid,
	input logic                             rsp_ready,
	input logic [lli_pkg::LOG_W-1:0]        rsp_log_out
);

	// evaluations accepted but not yet delivered
	logic [7:0] pend_q;
	logic       ev_acc;
	logic       rsp_acc;

	assign ev_acc  = req_valid && req_ready && req_cmd;
	assign rsp_acc = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 8'd0;
		end else begin
			case ({ev_acc, rsp_acc})
				2'b10:   pend_q <= pend_q + 8'd1;
				2'b01:   pend_q <= pend_q - 8'd1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_log_out))
		else $error("result dropped or changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 8'd0)
		else $error("result without an outstanding evaluation");

	a_ready_when_light: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q < 8'd3 |-> req_ready)
		else $error("input stalled with fewer than three evaluations in flight");

	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid)
		else $error("input stalled while no result waits");

endmodule

bind fixed_point_log_interp_lookup lli_chk u_lli_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.req_cmd     (req.cmd),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_log_out (rsp.log_out)
);

[tb/fixed_point_log_interp_lookup_tb.sv]
module fixed_point_log_interp_lookup_tb;

	localparam int DEPTH = lli_pkg::TABLE_DEPTH_DEF;
	// pipeline is 52 deep, table writes give no result so allow a little more
	localparam int DRAIN_CYCLES = 64;
	localparam int PHASE_ITEMS = 50;
	localparam int PHASES = 7;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_EVAL  = 1'b1;
	localparam logic [lli_pkg::CFG_ADDR_W-1:0] REG_NONE = 2'd3;

	typedef struct packed {
		logic [lli_pkg::CFG_ADDR_W-1:0] index;
		logic [lli_pkg::CFG_DATA_W-1:0] data;
	} reg_write_t;

	logic clk;
	logic arst_n;

	lli_req_if req_ch ();
	lli_rsp_if rsp_ch ();
	lli_cfg_if cfg_ch ();

	fixed_point_log_interp_lookup #(.TABLE_DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// shadow of the block's table and registers
	logic signed [lli_pkg::DATA_W-1:0] lut_shadow [DEPTH];
	logic [lli_pkg::STEP_W-1:0]  cur_step  = lli_pkg::STEP_RST;
	logic [lli_pkg::START_W-1:0] cur_start = lli_pkg::START_RST;
	logic [lli_pkg::COUNT_W-1:0] cur_count = lli_pkg::COUNT_RST;

	logic signed [lli_pkg::LOG_W-1:0] exp_log [$];
	reg_write_t reg_writes [$];
	int mismatch_cnt = 0;
	int burst_left = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic longint eff_step();
		return (cur_step == '0) ? 64'sd1 : longint'(cur_step);
	endfunction

	function automatic longint eff_count();
		longint n;
		n = (cur_count == '0) ? 64'sd1 : longint'(cur_count);
		if (n > DEPTH)
			n = DEPTH;
		return n;
	endfunction

	// clamp below and above the sampled range, interpolate in between
	function automatic logic signed [lli_pkg::LOG_W-1:0] predict_log(
			input logic signed [lli_pkg::VALUE_W-1:0] x);
		longint stp, n, d, k, base, t0, t1, r;
		stp = eff_step();
		n = eff_count();
		d = longint'(x) - longint'(cur_start);
		k = d / stp;
		if (k >= n - 1) begin
			r = longint'(lut_shadow[n - 1]);
		end else if (k < 0) begin
			r = longint'(lut_shadow[0]);
		end else begin
			base = k * stp;
			if (d > base) begin
				t0 = longint'(lut_shadow[k]);
				t1 = longint'(lut_shadow[k + 1]);
				r = t0 + ((t1 - t0) * (d - base)) / stp;
			end else begin
				r = longint'(lut_shadow[k]);
			end
		end
		return r[lli_pkg::LOG_W-1:0];
	endfunction

	// mostly around the sampled range, some near sample points, some anywhere
	function automatic logic signed [lli_pkg::VALUE_W-1:0] pick_arg();
		longint stp, n, a, k;
		int sel;
		stp = eff_step();
		n = eff_count();
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return $urandom;
		if (sel <= 2) begin
			case ($urandom_range(0, 3))
				0: k = 0;
				1: k = n - 1;
				2: k = (n > 1) ? n - 2 : 0;
				default: k = $urandom_range(0, 32'(n - 1));
			endcase
			a = longint'(cur_start) + stp * k + $urandom_range(0, 2) - 1;
		end else begin
			a = longint'(cur_start) - stp + longint'($urandom_range(0, 32'(stp * (n + 1))));
		end
		return a[lli_pkg::VALUE_W-1:0];
	endfunction

	task automatic send_item(input logic c, input logic signed [lli_pkg::VALUE_W-1:0] v,
			input logic [lli_pkg::INDEX_W-1:0] k,
			input logic signed [lli_pkg::DATA_W-1:0] dat);
		int gap;
		req_ch.valid <= 1'b1;
		req_ch.cmd <= c;
		req_ch.value_in <= v;
		req_ch.entry_index <= k;
		req_ch.entry_data <= dat;
		do @(posedge clk); while (!req_ch.ready);
		if (c == CMD_EVAL)
			exp_log.push_back(predict_log(v));
		else
			lut_shadow[k] = dat;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(80, 250)
				: $urandom_range(0, 24);
			gap = $urandom_range(1, 10);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic eval_at(input logic signed [lli_pkg::VALUE_W-1:0] x);
		send_item(CMD_EVAL, x, lli_pkg::INDEX_W'($urandom), lli_pkg::DATA_W'($urandom));
	endtask

	task automatic write_entry(input logic [lli_pkg::INDEX_W-1:0] k,
			input logic signed [lli_pkg::DATA_W-1:0] dat);
		send_item(CMD_WRITE, $urandom, k, dat);
	endtask

	// stop sending, let every result and in-flight table write drain
	task automatic quiesce();
		req_ch.valid <= 1'b0;
		while (exp_log.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apply_reg_writes();
		reg_write_t w;
		while (reg_writes.size() != 0) begin
			w = reg_writes.pop_front();
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= w.index;
			cfg_ch.data <= w.data;
			do @(posedge clk); while (!cfg_ch.ready);
			case (w.index)
				lli_pkg::REG_SAMPLE_STEP: cur_step = w.data[lli_pkg::STEP_W-1:0];
				lli_pkg::REG_START_VALUE: cur_start = w.data[lli_pkg::START_W-1:0];
				lli_pkg::REG_ENTRY_COUNT: cur_count = w.data[lli_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_regs(input logic [lli_pkg::CFG_DATA_W-1:0] step,
			input logic [lli_pkg::CFG_DATA_W-1:0] start,
			input logic [lli_pkg::CFG_DATA_W-1:0] count);
		quiesce();
		reg_writes.push_back('{lli_pkg::REG_SAMPLE_STEP, step});
		reg_writes.push_back('{lli_pkg::REG_START_VALUE, start});
		reg_writes.push_back('{lli_pkg::REG_ENTRY_COUNT, count});
		apply_reg_writes();
	endtask

	// reset values: one entry in use, so everything reads entry zero
	task automatic test_default_regs();
		write_entry(0, 16'sh7fff);
		eval_at(32'sh8000_0000);
		eval_at(32'sh7fff_ffff);
		eval_at(32'sd4095);
		eval_at(32'sd4096);
		eval_at(32'sd4097);
		write_entry(0, -16'sd32768);
		eval_at(32'sd0);
	endtask

	// every entry gets written so no evaluation reads an unwritten one
	task automatic load_table();
		for (int i = 0; i < DEPTH; i++) begin
			case (i)
				0, 2, DEPTH - 1: write_entry(lli_pkg::INDEX_W'(i), -16'sd32768);
				1, DEPTH - 2: write_entry(lli_pkg::INDEX_W'(i), 16'sh7fff);
				default: write_entry(lli_pkg::INDEX_W'(i), lli_pkg::DATA_W'($urandom));
			endcase
		end
	endtask

	// widest step with full-swing neighbors gives the largest products
	task automatic test_interp_extremes();
		set_regs(30'd65535, 30'd0, 30'd1024);
		eval_at(32'sd1);
		eval_at(32'sd65534);
		eval_at(32'sd65535);
		eval_at(32'sd65536);
		eval_at(-32'sd1);
		eval_at(-32'sd65535);
		eval_at(32'sd65535 * 1022 + 1);
		eval_at(32'sd65535 * 1023);
		eval_at(32'sh7fff_ffff);
	endtask

	task automatic test_reg_corner_cases();
		// zero step and zero count behave as one
		set_regs(30'd0, 30'd4096, 30'd0);
		eval_at(32'sd4100);
		eval_at(-32'sd5);
		// count above the depth saturates
		set_regs(30'd0, 30'd4096, 30'h7ff);
		eval_at(32'sd4101);
		eval_at(32'sd4096 + 1022);
		eval_at(32'sd4096 + 1023);
		eval_at(32'sh7fff_ffff);
		// a write to the unused index changes nothing
		quiesce();
		reg_writes.push_back('{REG_NONE, lli_pkg::CFG_DATA_W'($urandom)});
		apply_reg_writes();
		eval_at(32'sd4096 + 1022);
		// only the low bits of each register are kept
		set_regs(30'h3fff_0002, 30'd4096, 30'h3fff_f803);
		eval_at(32'sd4099);
		// start at its top, arguments at both ends of the signed range
		set_regs(30'd1, 30'h3fff_ffff, 30'd1024);
		eval_at(32'sh7fff_ffff);
		eval_at(32'sh3fff_ffff + 500);
		eval_at(32'sh8000_0000);
	endtask

	task automatic test_random_traffic();
		logic [lli_pkg::CFG_DATA_W-1:0] step, start, count;
		for (int p = 0; p < PHASES; p++) begin
			if (p == 0) begin
				step = 1;
				start = 0;
				count = 2;
			end else if (p == PHASES - 1) begin
				step = 65535;
				start = 30'h3fff_ffff;
				count = 1024;
			end else begin
				case ($urandom_range(0, 2))
					0: step = 1;
					1: step = lli_pkg::CFG_DATA_W'($urandom_range(1, 16));
					default: step = lli_pkg::CFG_DATA_W'($urandom_range(1, 65535));
				endcase
				start = ($urandom_range(0, 1) == 0)
					? lli_pkg::CFG_DATA_W'($urandom_range(0, 8192))
					: lli_pkg::CFG_DATA_W'($urandom_range(0, 30'h3fff_ffff));
				count = ($urandom_range(0, 3) == 0)
					? lli_pkg::CFG_DATA_W'($urandom_range(1, 1024))
					: lli_pkg::CFG_DATA_W'($urandom_range(2, 32));
			end
			set_regs(step, start, count);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(0, 4) == 0)
					write_entry(lli_pkg::INDEX_W'($urandom), lli_pkg::DATA_W'($urandom));
				else
					eval_at(pick_arg());
			end
		end
	endtask

	// receiver: short stalls, with long runs of no stalling now and then
	initial begin
		int run_left;
		int stall_left;
		run_left = 0;
		stall_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (run_left > 0) begin
				run_left--;
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= 1'b0;
				if (stall_left == 0)
					stall_left = $urandom_range(1, 8);
				stall_left--;
				if (stall_left == 0)
					run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
						: $urandom_range(1, 12);
			end
		end
	end

	always @(posedge clk) begin
		logic signed [lli_pkg::LOG_W-1:0] want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (exp_log.size() == 0) begin
				mismatch_cnt++;
				$display("%0t: unexpected transaction, expected none, actual log_out %0d",
					$time, rsp_ch.log_out);
			end else begin
				want = exp_log.pop_front();
				if (rsp_ch.log_out !== want) begin
					mismatch_cnt++;
					$display("%0t: log_out mismatch, expected %0d, actual %0d",
						$time, want, rsp_ch.log_out);
				end
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.cmd <= CMD_WRITE;
		req_ch.value_in <= '0;
		req_ch.entry_index <= '0;
		req_ch.entry_data <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= lli_pkg::REG_SAMPLE_STEP;
		cfg_ch.data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_regs();
		load_table();
		test_interp_extremes();
		test_reg_corner_cases();
		test_random_traffic();

		quiesce();
		if (mismatch_cnt == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[sim.f]
rtl/lli_pkg.sv
rtl/lli_if.sv
rtl/lli_ram.sv
rtl/lli_div.sv
rtl/fixed_point_log_interp_lookup.sv
rtl/lli_chk.sv
tb/fixed_point_log_interp_lookup_tb.sv
